### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

### rtl/lsgf_pkg.sv
// ----------------------------------------------------------------------------
// lsgf_pkg
// Types and constants shared by the subpixel glyph filter modules.
// ----------------------------------------------------------------------------
package lsgf_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_GAIN     = 2'd0,
        REG_FG_RED   = 2'd1,
        REG_FG_GREEN = 2'd2,
        REG_FG_BLUE  = 2'd3
    } cfg_reg_t;

    // Color channels
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Filter weights (sum 256) and rounding term
    localparam logic [7:0]  W_EDGE   = 8'h55;
    localparam logic [7:0]  W_CENTER = 8'h56;
    localparam logic [16:0] FIR_ROUND = 17'd128;
    localparam logic [7:0]  FULL_SCALE = 8'd255;

    // Spill results that follow the last sample of a row
    localparam logic [1:0] ROW_SPILLS = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROD,
        ST_SCALE,
        ST_FILTER
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_sample;
        logic zero_sample;
        logic prod_en;
        logic scale_en;
        logic filter_en;
        logic row_clear;
        logic item_done;
        logic row_end;
    } dp_cmd_t;

endpackage

### rtl/lsgf_ctrl.sv
// ----------------------------------------------------------------------------
// lsgf_ctrl
// Sequencer: steps each result through the boost and filter datapath and
// counts the spill results of a row end. Owns the output valid flag.
// ----------------------------------------------------------------------------
module lsgf_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             last_in_row,
    output logic             out_valid,
    input  logic             out_ready,
    output lsgf_pkg::dp_cmd_t cmd
);
    import lsgf_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] spill_reg, spill_next;
    logic       last_reg, last_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            spill_reg     <= 2'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            spill_reg     <= spill_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        spill_next     = spill_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_sample = 1'b1;
                    last_next       = last_in_row;
                    spill_next      = last_in_row ? ROW_SPILLS : 2'd0;
                    state_next      = ST_PROD;
                end
            end
            ST_PROD:
            begin
                cmd.prod_en = 1'b1;
                state_next  = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = ST_FILTER;
            end
            ST_FILTER:
            begin
                // wait here while the previous result is still held
                if (out_free)
                begin
                    cmd.filter_en  = 1'b1;
                    out_valid_next = 1'b1;
                    if (spill_reg != 2'd0)
                    begin
                        cmd.zero_sample = 1'b1;
                        spill_next      = spill_reg - 2'd1;
                        state_next      = ST_PROD;
                    end
                    else
                    begin
                        cmd.item_done = 1'b1;
                        cmd.row_end   = last_reg;
                        cmd.row_clear = last_reg;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/lsgf_datapath.sv
// ----------------------------------------------------------------------------
// lsgf_datapath
// Configuration registers, dark-glyph boost (two registered multiply steps),
// three-tap window, channel counter and the output register.
// ----------------------------------------------------------------------------
module lsgf_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic [7:0]        sample,
    input  lsgf_pkg::dp_cmd_t cmd,
    output logic [7:0]        alpha,
    output logic [1:0]        channel,
    output logic              item_done,
    output logic              row_end
);
    import lsgf_pkg::*;

    logic [7:0]  gain_reg;
    logic [7:0]  fg_red_reg;
    logic [7:0]  fg_green_reg;
    logic [7:0]  fg_blue_reg;

    logic [7:0]  sample_reg;
    logic [7:0]  contrast_reg;
    logic [13:0] prod_reg;
    logic [5:0]  boost_add_reg;
    logic [7:0]  tap_older_reg;
    logic [7:0]  tap_newer_reg;
    logic [1:0]  channel_reg;

    logic [7:0]  alpha_reg;
    logic [1:0]  out_channel_reg;
    logic        item_done_reg;
    logic        row_end_reg;

    logic [7:0]  fg_sel;
    logic [15:0] contrast_full;
    logic [15:0] prod_full;
    logic [21:0] scale_full;
    logic [8:0]  boost_sum;
    logic [7:0]  boosted;
    logic [16:0] acc;

    // Configuration writes; all indexes are defined
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= 8'd0;
            fg_red_reg   <= 8'd0;
            fg_green_reg <= 8'd0;
            fg_blue_reg  <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN:     gain_reg     <= cfg_data;
                REG_FG_RED:   fg_red_reg   <= cfg_data;
                REG_FG_GREEN: fg_green_reg <= cfg_data;
                REG_FG_BLUE:  fg_blue_reg  <= cfg_data;
                default:      gain_reg     <= gain_reg;
            endcase
        end
    end

    // Foreground component of the current channel
    always_comb
    begin
        case (channel_reg)
            CH_RED:   fg_sel = fg_red_reg;
            CH_GREEN: fg_sel = fg_green_reg;
            default:  fg_sel = fg_blue_reg;
        endcase
    end

    // Boost arithmetic
    assign contrast_full = 16'(FULL_SCALE - fg_sel) * 16'(gain_reg);
    assign prod_full     = 16'(sample_reg) * 16'(FULL_SCALE - sample_reg);
    assign scale_full    = 22'(contrast_reg) * 22'(prod_reg);
    assign boost_sum     = {1'b0, sample_reg} + {3'd0, boost_add_reg};
    assign boosted       = boost_sum[8] ? FULL_SCALE : boost_sum[7:0];

    // Rounded 0x55/0x56/0x55 filter
    assign acc = 17'(tap_older_reg) * 17'(W_EDGE)
               + 17'(tap_newer_reg) * 17'(W_CENTER)
               + 17'(boosted) * 17'(W_EDGE)
               + FIR_ROUND;

    // Sample and multiply stages
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
            sample_reg <= sample;
        else if (cmd.zero_sample)
            sample_reg <= 8'd0;
        if (cmd.prod_en)
        begin
            contrast_reg <= contrast_full[15:8];
            prod_reg     <= prod_full[13:0];
        end
        if (cmd.scale_en)
            boost_add_reg <= scale_full[21:16];
    end

    // Window taps and channel counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_older_reg <= 8'd0;
            tap_newer_reg <= 8'd0;
            channel_reg   <= CH_BLUE;
        end
        else if (cmd.filter_en)
        begin
            if (cmd.row_clear)
            begin
                tap_older_reg <= 8'd0;
                tap_newer_reg <= 8'd0;
                channel_reg   <= CH_BLUE;
            end
            else
            begin
                tap_older_reg <= tap_newer_reg;
                tap_newer_reg <= boosted;
                channel_reg   <= (channel_reg == CH_BLUE) ? CH_RED : channel_reg + 2'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.filter_en)
        begin
            alpha_reg       <= acc[15:8];
            out_channel_reg <= channel_reg;
            item_done_reg   <= cmd.item_done;
            row_end_reg     <= cmd.row_end;
        end
    end

    assign alpha     = alpha_reg;
    assign channel   = out_channel_reg;
    assign item_done = item_done_reg;
    assign row_end   = row_end_reg;

endmodule

### rtl/lcd_subpixel_glyph_filter.sv
// ----------------------------------------------------------------------------
// lcd_subpixel_glyph_filter
// Dark-glyph contrast boost followed by a rounded three-tap subpixel filter.
// ----------------------------------------------------------------------------
//  channel  | signals                              | direction
//  ---------+--------------------------------------+----------
//  input    | in_valid, in_ready, sample, last_in_row | in (in_ready out)
//  output   | out_valid, out_ready, alpha, channel, item_done, row_end | out (out_ready in)
//  config   | cfg_we, cfg_index, cfg_data          | in, write only
//
// Each result passes through the product, scale and filter steps, set by the
// two dependent multiplies of the boost. An item is accepted from idle, and a
// row-end item (three results) keeps the input closed until its last filter step.
// Reset clears the window, sets the channel to blue and zeroes the
// configuration registers.
// A held result stalls the filter step until out_ready takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcd_subpixel_glyph_filter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] sample,
    input  logic       last_in_row,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] alpha,
    output logic [1:0] channel,
    output logic       item_done,
    output logic       row_end
);
    import lsgf_pkg::*;

    dp_cmd_t cmd;

    // Sequencer
    lsgf_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .last_in_row (last_in_row),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd)
    );

    // Arithmetic and state
    lsgf_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .alpha     (alpha),
        .channel   (channel),
        .item_done (item_done),
        .row_end   (row_end)
    );

    // A row end is always the last result of its item
    `ASSERT_CLK(a_row_end_done, (out_valid && row_end) |-> item_done, "row_end without item_done")

    // An accepted item keeps the input closed while it is processed
    `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "input reopened early")

    // A stalled result stays valid until it is taken
    `ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> out_valid, "held result dropped")

    // A stalled result keeps its alpha
    `ASSERT_CLK(a_out_stable, (out_valid && !out_ready) |=> $stable(alpha), "held alpha changed")

    // No result is ever made while an item is being accepted
    `ASSERT_NEVER(a_no_filter_in_idle, in_ready && cmd.filter_en, "filter step while idle")

endmodule
